### hdl/mprm_pkg.sv
`default_nettype none
package mprm_pkg;

  localparam int CHANNELS    = 16;
  localparam int CH_BITS     = 4;
  localparam int SAMPLE_BITS = 24;
  localparam int MAG_BITS    = 24;
  localparam int SQ_BITS     = 48;
  localparam int ENERGY_BITS = 64;
  localparam int COUNT_BITS  = 24;
  localparam int HOLD_BITS   = 6;
  localparam int CIU_BITS    = 5;
  localparam int LOG_BITS    = 22;
  localparam int FRAC_BITS   = 16;
  localparam int REL_BITS    = 26;
  localparam int ABS_BITS    = 25;
  localparam int K_BITS      = 22;
  localparam int PROD_BITS   = ABS_BITS + K_BITS;
  localparam int LEVEL_BITS  = 10;

  localparam logic [K_BITS-1:0]     DB_K       = 22'd3945660;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = 24'hFFFFFF;
  localparam logic [LEVEL_BITS-1:0] FLOOR_LVL  = 10'sd500;
  localparam logic [LEVEL_BITS-1:0] LEVEL_MIN  = -10'sd500;
  localparam logic [LOG_BITS-1:0]   PEAK_REF   = 22'(23 << 16);
  localparam logic [LOG_BITS-1:0]   ENERGY_REF = 22'(46 << 16);

  localparam logic [1:0] REG_CHANNELS_IN_USE = 2'd0;
  localparam logic [1:0] REG_HOLD_TICKS      = 2'd1;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  typedef enum logic [1:0] {
    LG_IDLE,
    LG_BYTE,
    LG_BIT,
    LG_SQ
  } log_state_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SAMP,
    ST_CNT,
    ST_CNTW,
    ST_RD,
    ST_PK,
    ST_PKW,
    ST_PKL,
    ST_EN,
    ST_ENW,
    ST_ENL,
    ST_EMIT,
    ST_FIN
  } meter_state_t;

  typedef struct packed {
    logic                   rd_en;
    logic [CH_BITS-1:0]     rd_addr;
    logic [CH_BITS-1:0]     wr_addr;
    logic                   acc_we;
    logic [MAG_BITS-1:0]    peak;
    logic [ENERGY_BITS-1:0] energy;
    logic                   hold_we;
    logic [HOLD_BITS-1:0]   hold;
    logic                   clear;
  } store_req_t;

  typedef struct packed {
    logic [MAG_BITS-1:0]    peak;
    logic [ENERGY_BITS-1:0] energy;
    logic [HOLD_BITS-1:0]   hold;
  } store_rsp_t;

endpackage
`default_nettype wire

### hdl/multichannel_peak_rms_meter_unit.sv
`default_nettype none
// Multichannel peak / RMS level meter.
// Input stream (s_axis): one beat is an audio sample or a refresh tick,
// told apart by tuser. A sample updates its channel's peak and energy in
// the channel store; samples of channels not in use are dropped. Channel 0
// samples also advance the frame counter.
// A sample takes the store read, then the read-modify-write.
// A tick walks the channels in use and sends one report beat per channel on
// m_axis, tlast on the last one, then clears peak, energy and the frame
// counter. Each channel runs up to two log2 evaluations in the shared
// iterative unit (normalisation, then the 16 squaring rounds) and two dB
// conversions; the frame counter log2 comes first and the clear last.
// Output beats sit in a register; when the receiver stalls, the walk holds
// at that channel and no new input beat is taken until the tick is done.
// Reset (synchronous, active high) empties all channel accumulators and
// overload holds through valid bits at once; no clearing pass is needed.
// Configuration writes are taken at any cycle by cfg_we; use them while idle.
module multichannel_peak_rms_meter_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // channel[3:0], sample_value[27:4]
  input  wire logic [0:0]  s_axis_tuser,  // func[0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // channel_res[3:0], rms_level[13:4],
                                          // peak_level[23:14], overload[24]
  output logic             m_axis_tlast,  // last
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [5:0]  cfg_data
);

  localparam int CHB = mprm_pkg::CH_BITS;
  localparam int LVB = mprm_pkg::LEVEL_BITS;

  mprm_pkg::meter_state_t state, state_next;
  mprm_pkg::store_req_t   req;
  mprm_pkg::store_rsp_t   rsp;

  logic [mprm_pkg::CIU_BITS-1:0]   ciu;
  logic [mprm_pkg::HOLD_BITS-1:0]  hold_ticks;
  logic [mprm_pkg::CIU_BITS-1:0]   n_used;
  logic [CHB-1:0]                  ch, ch_next;
  logic [CHB-1:0]                  samp_ch;
  logic [mprm_pkg::MAG_BITS-1:0]   samp_mag, in_mag, in_raw;
  logic [mprm_pkg::SQ_BITS-1:0]    samp_sq;
  logic [mprm_pkg::COUNT_BITS-1:0] count, count_next;
  logic [mprm_pkg::LOG_BITS-1:0]   lc, lc_next;
  logic signed [LVB-1:0]           rms_t, rms_next, peak_t, peak_next;
  logic [CHB-1:0]                  in_ch;
  logic                            in_acc, ch_last, out_free;
  logic [mprm_pkg::ENERGY_BITS:0]  esum;
  logic [6:0]                      hold_inc;
  logic [mprm_pkg::HOLD_BITS-1:0]  hold_new;

  logic                                  log_start, log_done;
  logic [mprm_pkg::ENERGY_BITS-1:0]      log_x;
  logic [mprm_pkg::LOG_BITS-1:0]         log_res;
  logic                                  lvl_start, lvl_done, lvl_sh;
  logic signed [mprm_pkg::REL_BITS-1:0]  lvl_rel;
  logic signed [LVB-1:0]                 lvl_out;
  logic                                  out_load;

  mprm_store u_store (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  mprm_log2 u_log2 (
    .clk(clk), .rst(rst), .start(log_start), .x(log_x),
    .done(log_done), .result(log_res)
  );

  mprm_level u_level (
    .clk(clk), .rst(rst), .start(lvl_start), .rel(lvl_rel),
    .shift33(lvl_sh), .done(lvl_done), .level(lvl_out)
  );

  assign in_ch  = s_axis_tdata[CHB-1:0];
  assign in_raw = s_axis_tdata[CHB +: mprm_pkg::MAG_BITS];
  assign in_mag = in_raw[mprm_pkg::MAG_BITS-1] ? -in_raw : in_raw;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // zero means one channel, anything past the store saturates
  always_comb begin
    if (ciu == '0)
      n_used = mprm_pkg::CIU_BITS'(1);
    else if (ciu > mprm_pkg::CIU_BITS'(mprm_pkg::CHANNELS))
      n_used = mprm_pkg::CIU_BITS'(mprm_pkg::CHANNELS);
    else
      n_used = ciu;
  end

  assign ch_last  = ({1'b0, ch} + 5'd1) == n_used;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign esum     = {1'b0, rsp.energy} + 65'(samp_sq);

  // overload hold: restart on full scale, else count up while running
  always_comb begin
    if (peak_t == '0)
      hold_inc = 7'd1;
    else if (rsp.hold != '0)
      hold_inc = {1'b0, rsp.hold} + 7'd1;
    else
      hold_inc = '0;
    hold_new = (hold_inc >= {1'b0, hold_ticks}) ? '0 : hold_inc[5:0];
  end

  always_comb begin
    state_next    = state;
    ch_next       = ch;
    count_next    = count;
    lc_next       = lc;
    rms_next      = rms_t;
    peak_next     = peak_t;
    s_axis_tready = 1'b0;
    log_start     = 1'b0;
    log_x         = rsp.energy;
    lvl_start     = 1'b0;
    lvl_rel       = $signed({4'd0, log_res}) - $signed({4'd0, mprm_pkg::PEAK_REF});
    lvl_sh        = 1'b0;
    out_load      = 1'b0;
    req           = '0;
    req.wr_addr   = samp_ch;
    req.peak      = (samp_mag > rsp.peak) ? samp_mag : rsp.peak;
    req.energy    = esum[mprm_pkg::ENERGY_BITS] ? '1 : esum[mprm_pkg::ENERGY_BITS-1:0];
    req.hold      = hold_new;
    case (state)
      mprm_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        req.rd_addr   = in_ch;
        if (in_acc) begin
          if (s_axis_tuser[0] == mprm_pkg::FUNC_TICK) begin
            ch_next    = '0;
            state_next = mprm_pkg::ST_CNT;
          end else if ({1'b0, in_ch} < n_used) begin
            req.rd_en  = 1'b1;
            state_next = mprm_pkg::ST_SAMP;
          end
        end
      end
      mprm_pkg::ST_SAMP: begin
        req.acc_we = 1'b1;
        if (samp_ch == '0 && count != mprm_pkg::COUNT_MAX)
          count_next = count + 24'd1;
        state_next = mprm_pkg::ST_IDLE;
      end
      mprm_pkg::ST_CNT: begin
        log_x = 64'(count);
        if (count != '0) begin
          log_start  = 1'b1;
          state_next = mprm_pkg::ST_CNTW;
        end else begin
          state_next = mprm_pkg::ST_RD;
        end
      end
      mprm_pkg::ST_CNTW: begin
        if (log_done) begin
          lc_next    = log_res;
          state_next = mprm_pkg::ST_RD;
        end
      end
      mprm_pkg::ST_RD: begin
        req.rd_en   = 1'b1;
        req.rd_addr = ch;
        state_next  = mprm_pkg::ST_PK;
      end
      mprm_pkg::ST_PK: begin
        log_x = 64'(rsp.peak);
        if (rsp.peak == '0) begin
          peak_next  = mprm_pkg::LEVEL_MIN;
          state_next = mprm_pkg::ST_EN;
        end else begin
          log_start  = 1'b1;
          state_next = mprm_pkg::ST_PKW;
        end
      end
      mprm_pkg::ST_PKW: begin
        if (log_done) begin
          lvl_start  = 1'b1;
          state_next = mprm_pkg::ST_PKL;
        end
      end
      mprm_pkg::ST_PKL: begin
        if (lvl_done) begin
          peak_next  = lvl_out;
          state_next = mprm_pkg::ST_EN;
        end
      end
      mprm_pkg::ST_EN: begin
        if (rsp.energy == '0 || count == '0) begin
          rms_next   = mprm_pkg::LEVEL_MIN;
          state_next = mprm_pkg::ST_EMIT;
        end else begin
          log_start  = 1'b1;
          state_next = mprm_pkg::ST_ENW;
        end
      end
      mprm_pkg::ST_ENW: begin
        lvl_sh  = 1'b1;
        lvl_rel = $signed({4'd0, log_res}) - $signed({4'd0, lc})
                - $signed({4'd0, mprm_pkg::ENERGY_REF});
        if (log_done) begin
          lvl_start  = 1'b1;
          state_next = mprm_pkg::ST_ENL;
        end
      end
      mprm_pkg::ST_ENL: begin
        if (lvl_done) begin
          rms_next   = lvl_out;
          state_next = mprm_pkg::ST_EMIT;
        end
      end
      mprm_pkg::ST_EMIT: begin
        req.wr_addr = ch;
        if (out_free) begin
          out_load    = 1'b1;
          req.hold_we = 1'b1;
          if (ch_last) begin
            state_next = mprm_pkg::ST_FIN;
          end else begin
            ch_next    = ch + 4'd1;
            state_next = mprm_pkg::ST_RD;
          end
        end
      end
      mprm_pkg::ST_FIN: begin
        req.clear  = 1'b1;
        count_next = '0;
        state_next = mprm_pkg::ST_IDLE;
      end
      default: state_next = mprm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= mprm_pkg::ST_IDLE;
      count         <= '0;
      ciu           <= 5'd8;
      hold_ticks    <= 6'd10;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cfg_we && cfg_index == mprm_pkg::REG_CHANNELS_IN_USE)
        ciu <= cfg_data[mprm_pkg::CIU_BITS-1:0];
      if (cfg_we && cfg_index == mprm_pkg::REG_HOLD_TICKS)
        hold_ticks <= cfg_data;
      if (out_load)
        m_axis_tvalid <= 1'b1;
      else if (m_axis_tready)
        m_axis_tvalid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ch     <= ch_next;
    lc     <= lc_next;
    rms_t  <= rms_next;
    peak_t <= peak_next;
    if (in_acc) begin
      samp_ch  <= in_ch;
      samp_mag <= in_mag;
      samp_sq  <= mprm_pkg::SQ_BITS'(in_mag) * mprm_pkg::SQ_BITS'(in_mag);
    end
    if (out_load) begin
      m_axis_tdata <= {7'd0, (hold_new != '0), peak_t, rms_t, ch};
      m_axis_tlast <= ch_last;
    end
  end

endmodule
`default_nettype wire

### hdl/mprm_log2.sv
`default_nettype none
module mprm_log2 (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [mprm_pkg::ENERGY_BITS-1:0] x,
  output logic                                 done,
  output logic [mprm_pkg::LOG_BITS-1:0]        result
);

  mprm_pkg::log_state_t state, state_next;
  logic [mprm_pkg::ENERGY_BITS-1:0] norm;
  logic [5:0]  e;
  logic [30:0] y;
  logic [3:0]  cnt;
  logic [mprm_pkg::FRAC_BITS-1:0] frac;
  logic [61:0] prod;
  logic [31:0] t;

  assign prod = 62'(y) * 62'(y);
  assign t    = prod[61:30];

  always_comb begin
    state_next = state;
    case (state)
      mprm_pkg::LG_IDLE: begin
        if (start)
          state_next = mprm_pkg::LG_BYTE;
      end
      mprm_pkg::LG_BYTE: begin
        if (norm[63:56] != 8'd0)
          state_next = mprm_pkg::LG_BIT;
      end
      mprm_pkg::LG_BIT: begin
        if (norm[63])
          state_next = mprm_pkg::LG_SQ;
      end
      mprm_pkg::LG_SQ: begin
        if (cnt == 4'd15)
          state_next = mprm_pkg::LG_IDLE;
      end
      default: state_next = mprm_pkg::LG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mprm_pkg::LG_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == mprm_pkg::LG_SQ) && (cnt == 4'd15);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      mprm_pkg::LG_IDLE: begin
        if (start) begin
          norm <= x;
          e    <= 6'd63;
        end
      end
      mprm_pkg::LG_BYTE: begin
        if (norm[63:56] == 8'd0) begin
          norm <= {norm[55:0], 8'd0};
          e    <= e - 6'd8;
        end
      end
      mprm_pkg::LG_BIT: begin
        if (!norm[63]) begin
          norm <= {norm[62:0], 1'b0};
          e    <= e - 6'd1;
        end else begin
          y   <= norm[63:33];
          cnt <= 4'd0;
        end
      end
      mprm_pkg::LG_SQ: begin
        frac <= {frac[14:0], t[31]};
        y    <= t[31] ? t[31:1] : t[30:0];
        cnt  <= cnt + 4'd1;
      end
      default: begin
      end
    endcase
  end

  assign result = {e, frac};

endmodule
`default_nettype wire

### hdl/mprm_level.sv
`default_nettype none
module mprm_level (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  input  wire logic signed [mprm_pkg::REL_BITS-1:0] rel,
  input  wire logic                                 shift33,
  output logic                                      done,
  output logic signed [mprm_pkg::LEVEL_BITS-1:0]    level
);

  logic v1, v2;
  logic [mprm_pkg::ABS_BITS-1:0]  absr;
  logic [mprm_pkg::REL_BITS-1:0]  neg;
  logic nonneg1, nonneg2, sh1, sh2;
  logic [mprm_pkg::PROD_BITS-1:0] prod;
  logic [mprm_pkg::PROD_BITS:0]   sum;
  logic [15:0] t;

  assign neg = -rel;

  // round up toward the floor side, then clip
  always_comb begin
    if (sh2) begin
      sum = {1'b0, prod} + 48'((64'd1 << 33) - 64'd1);
      t   = 16'(sum >> 33);
    end else begin
      sum = {1'b0, prod} + 48'((64'd1 << 32) - 64'd1);
      t   = 16'(sum >> 32);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      v2   <= v1;
      done <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      absr    <= rel[mprm_pkg::REL_BITS-1] ? neg[mprm_pkg::ABS_BITS-1:0] : '0;
      nonneg1 <= !rel[mprm_pkg::REL_BITS-1];
      sh1     <= shift33;
    end
    if (v1) begin
      prod    <= mprm_pkg::PROD_BITS'(absr) * mprm_pkg::PROD_BITS'(mprm_pkg::DB_K);
      nonneg2 <= nonneg1;
      sh2     <= sh1;
    end
    if (v2) begin
      if (nonneg2)
        level <= '0;
      else if (t > 16'(mprm_pkg::FLOOR_LVL))
        level <= mprm_pkg::LEVEL_MIN;
      else
        level <= -$signed(t[mprm_pkg::LEVEL_BITS-1:0]);
    end
  end

endmodule
`default_nettype wire

### hdl/mprm_store.sv
`default_nettype none
module mprm_store (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire mprm_pkg::store_req_t req,
  output mprm_pkg::store_rsp_t      rsp
);

  localparam int ACC_BITS = mprm_pkg::MAG_BITS + mprm_pkg::ENERGY_BITS;

  logic [ACC_BITS-1:0]            acc_mem  [mprm_pkg::CHANNELS];
  logic [mprm_pkg::HOLD_BITS-1:0] hold_mem [mprm_pkg::CHANNELS];
  logic [mprm_pkg::CHANNELS-1:0]  acc_vld, hold_vld;
  logic [ACC_BITS-1:0]            acc_q;
  logic [mprm_pkg::HOLD_BITS-1:0] hold_q;
  logic acc_qv, hold_qv;

  always_ff @(posedge clk) begin
    if (req.acc_we)
      acc_mem[req.wr_addr] <= {req.peak, req.energy};
    if (req.hold_we)
      hold_mem[req.wr_addr] <= req.hold;
    if (req.rd_en) begin
      acc_q  <= acc_mem[req.rd_addr];
      hold_q <= hold_mem[req.rd_addr];
    end
  end

  // valid bits: reset and tick clear empty the accumulators, reset alone the hold
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_vld  <= '0;
      hold_vld <= '0;
      acc_qv   <= 1'b0;
      hold_qv  <= 1'b0;
    end else begin
      if (req.rd_en) begin
        acc_qv  <= acc_vld[req.rd_addr];
        hold_qv <= hold_vld[req.rd_addr];
      end
      if (req.clear)
        acc_vld <= '0;
      else if (req.acc_we)
        acc_vld[req.wr_addr] <= 1'b1;
      if (req.hold_we)
        hold_vld[req.wr_addr] <= 1'b1;
    end
  end

  assign rsp.peak   = acc_qv ? acc_q[ACC_BITS-1:mprm_pkg::ENERGY_BITS] : '0;
  assign rsp.energy = acc_qv ? acc_q[mprm_pkg::ENERGY_BITS-1:0] : '0;
  assign rsp.hold   = hold_qv ? hold_q : '0;

endmodule
`default_nettype wire

### tb/multichannel_peak_rms_meter_unit_test.sv
`timescale 1ns / 100ps
`default_nettype none
module multichannel_peak_rms_meter_unit_test;

  // One level report as it leaves the meter.
  typedef struct packed {
    logic [3:0] chan;
    logic [9:0] rms;
    logic [9:0] peak;
    logic       ovl;
    logic       last;
  } report_t;

  localparam int IDLE_WAIT = 20;     // a sample needs a store read and a write; leave margin
  localparam int STALL_LIMIT = 8000; // cycles with no beat on either side

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [5:0]  cfg_data;

  multichannel_peak_rms_meter_unit dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Meter state as the predictor sees it.
  logic [4:0]        m_ciu;
  logic [5:0]        m_hold_ticks;
  longint unsigned   m_peak [mprm_pkg::CHANNELS];
  longint unsigned   m_energy [mprm_pkg::CHANNELS];
  int unsigned       m_count;
  int unsigned       m_hold [mprm_pkg::CHANNELS];

  report_t pending_reports[$];
  int      errors;
  int      n_samples, n_ticks, n_reports;
  int      burst_left;
  bit      bursty;
  int      hold_off_req;
  int      quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Q16 log2 of a positive integer, iterative squaring of the mantissa.
  function automatic int unsigned log2_q16(longint unsigned x);
    int unsigned e;
    int unsigned frac;
    longint unsigned y;
    e = 63;
    frac = 0;
    while (x[e] == 1'b0) e--;
    y = (e >= 30) ? (x >> (e - 30)) : (x << (30 - e));
    for (int i = 0; i < 16; i++) begin
      y = (y * y) >> 30;
      frac = frac << 1;
      if (y >= (64'd1 << 31)) begin
        frac |= 1;
        y = y >> 1;
      end
    end
    return (e << 16) | frac;
  endfunction

  // Scale a Q16 log2 ratio to tenths of dB, rounded toward -inf; zero or above gives 0, clipped at -500.
  function automatic int tenths_db(longint rel, int shift);
    longint unsigned a;
    longint unsigned t;
    if (rel >= 0) return 0;
    a = longint'(-rel) * 64'd3945660;
    t = (a + ((64'd1 << shift) - 1)) >> shift;
    if (t > 500) return -500;
    return -int'(t);
  endfunction

  function automatic int active_channels();
    int n;
    n = m_ciu;
    if (n < 1) n = 1;
    if (n > mprm_pkg::CHANNELS) n = mprm_pkg::CHANNELS;
    return n;
  endfunction

  function automatic void reset_model();
    m_ciu = 5'd8;
    m_hold_ticks = 6'd10;
    m_count = 0;
    for (int i = 0; i < mprm_pkg::CHANNELS; i++) begin
      m_peak[i] = 0;
      m_energy[i] = 0;
      m_hold[i] = 0;
    end
  endfunction

  // Update accumulators for a sample, or queue the reports a tick produces and clear the accumulators.
  function automatic void predict_meter(logic func, logic [3:0] ch, logic [23:0] val);
    int n;
    longint unsigned mag, sq;
    int rms_t, peak_t;
    report_t r;
    n = active_channels();
    if (func == mprm_pkg::FUNC_SAMPLE) begin
      n_samples++;
      if (ch >= n) return;
      mag = val[23] ? ((64'd1 << 24) - val) : val;
      if (mag > m_peak[ch]) m_peak[ch] = mag;
      sq = mag * mag;
      if (m_energy[ch] > (64'hFFFF_FFFF_FFFF_FFFF - sq))
        m_energy[ch] = 64'hFFFF_FFFF_FFFF_FFFF;
      else
        m_energy[ch] += sq;
      if (ch == 0 && m_count < 32'hFFFFFF) m_count++;
      return;
    end
    n_ticks++;
    for (int i = 0; i < n; i++) begin
      if (m_count == 0 || m_energy[i] == 0)
        rms_t = -500;
      else
        rms_t = tenths_db(longint'(log2_q16(m_energy[i])) - longint'(log2_q16(m_count))
                          - (longint'(46) << 16), 33);
      if (m_peak[i] == 0)
        peak_t = -500;
      else
        peak_t = tenths_db(longint'(log2_q16(m_peak[i])) - (longint'(23) << 16), 32);
      if (peak_t >= 0) m_hold[i] = 1;
      else if (m_hold[i] > 0) m_hold[i]++;
      if (m_hold[i] >= m_hold_ticks) m_hold[i] = 0;
      r.chan = i[3:0];
      r.rms = rms_t[9:0];
      r.peak = peak_t[9:0];
      r.ovl = (m_hold[i] != 0);
      r.last = (i + 1 == n);
      pending_reports.push_back(r);
    end
    for (int i = 0; i < mprm_pkg::CHANNELS; i++) begin
      m_peak[i] = 0;
      m_energy[i] = 0;
    end
    m_count = 0;
  endfunction

  // Offer one beat; gaps between bursts come before it.
  task automatic send_beat(logic func, logic [3:0] ch, logic [23:0] val);
    int gap;
    if (bursty) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= func;
    s_axis_tdata <= {4'b0, val, ch};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_meter(func, ch, val);
  endtask

  // Drop valid, wait for all reports plus margin for a trailing sample.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [5:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == mprm_pkg::REG_CHANNELS_IN_USE) m_ciu = val[4:0];
    else if (idx == mprm_pkg::REG_HOLD_TICKS) m_hold_ticks = val;
  endtask

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return 24'($urandom_range(0, 15)) ^ {24{$urandom_range(0, 1) == 1}};
      3: return 24'($urandom) >> $urandom_range(0, 23);
      default: return 24'($urandom);
    endcase
  endfunction

  // Extremes of every field, empty channels, full scale and the value just under it.
  task automatic test_directed();
    send_beat(mprm_pkg::FUNC_TICK, 4'hF, 24'hFFFFFF);     // all channels empty
    send_beat(mprm_pkg::FUNC_SAMPLE, 4'd0, 24'h800000);   // full scale negative
    send_beat(mprm_pkg::FUNC_SAMPLE, 4'd1, 24'h7FFFFF);   // just below full scale
    send_beat(mprm_pkg::FUNC_SAMPLE, 4'd2, 24'h000001);
    send_beat(mprm_pkg::FUNC_SAMPLE, 4'd3, 24'hFFFFFF);
    send_beat(mprm_pkg::FUNC_SAMPLE, 4'd7, 24'h000000);
    send_beat(mprm_pkg::FUNC_SAMPLE, 4'd15, 24'h555555);  // not in use, dropped
    send_beat(mprm_pkg::FUNC_SAMPLE, 4'd4, 24'hAAAAAA);
    send_beat(mprm_pkg::FUNC_TICK, 4'd0, 24'h0);
    // Channel 1 gets more samples than channel 0: RMS above full scale.
    send_beat(mprm_pkg::FUNC_SAMPLE, 4'd0, 24'h000010);
    repeat (4) send_beat(mprm_pkg::FUNC_SAMPLE, 4'd1, 24'h7FFFFF);
    send_beat(mprm_pkg::FUNC_TICK, 4'd5, 24'h0);
    repeat (3) send_beat(mprm_pkg::FUNC_TICK, 4'd0, 24'h0); // overload hold decay
    // Energy without frame count: channel 0 silent.
    send_beat(mprm_pkg::FUNC_SAMPLE, 4'd5, 24'h123456);
    send_beat(mprm_pkg::FUNC_TICK, 4'd0, 24'h0);
  endtask

  task automatic test_config_extremes();
    write_reg(mprm_pkg::REG_CHANNELS_IN_USE, 6'd16);
    write_reg(mprm_pkg::REG_HOLD_TICKS, 6'd50);
    send_beat(mprm_pkg::FUNC_SAMPLE, 4'd15, 24'h800000);
    send_beat(mprm_pkg::FUNC_SAMPLE, 4'd0, 24'h400000);
    repeat (3) send_beat(mprm_pkg::FUNC_TICK, 4'd0, 24'h0);
    write_reg(mprm_pkg::REG_CHANNELS_IN_USE, 6'd0);       // acts as one channel
    write_reg(mprm_pkg::REG_HOLD_TICKS, 6'd1);            // never shows overload
    send_beat(mprm_pkg::FUNC_SAMPLE, 4'd0, 24'h800000);
    send_beat(mprm_pkg::FUNC_SAMPLE, 4'd1, 24'h800000);
    send_beat(mprm_pkg::FUNC_TICK, 4'd0, 24'h0);
    write_reg(mprm_pkg::REG_CHANNELS_IN_USE, 6'd63);      // saturates to 16
    write_reg(mprm_pkg::REG_HOLD_TICKS, 6'd0);
    write_reg(2'd2, 6'd3);                                // beyond the list
    write_reg(2'd3, 6'd5);
    send_beat(mprm_pkg::FUNC_SAMPLE, 4'd9, 24'h800000);
    send_beat(mprm_pkg::FUNC_TICK, 4'd0, 24'h0);
    write_reg(mprm_pkg::REG_HOLD_TICKS, 6'd63);
    send_beat(mprm_pkg::FUNC_TICK, 4'd0, 24'h0);
  endtask

  // Mostly samples of channels in use, ticks now and then, new settings between phases.
  task automatic test_random();
    for (int phase = 0; phase < 3; phase++) begin
      write_reg(mprm_pkg::REG_CHANNELS_IN_USE, 6'($urandom_range(0, 63)));
      write_reg(mprm_pkg::REG_HOLD_TICKS, 6'($urandom_range(1, 8)));
      for (int i = 0; i < 16; i++) begin
        if ($urandom_range(0, 7) == 0)
          send_beat(mprm_pkg::FUNC_TICK, 4'($urandom), 24'($urandom));
        else if ($urandom_range(0, 5) == 0)
          send_beat(mprm_pkg::FUNC_SAMPLE, 4'($urandom), rand_sample());
        else
          send_beat(mprm_pkg::FUNC_SAMPLE, 4'($urandom_range(0, active_channels() - 1)),
                    rand_sample());
      end
      send_beat(mprm_pkg::FUNC_TICK, 4'd0, 24'h0);
    end
  endtask

  // Receiver holds off while ticks and samples keep coming.
  task automatic test_backpressure();
    write_reg(mprm_pkg::REG_CHANNELS_IN_USE, 6'd16);
    hold_off_req = 400;
    for (int i = 0; i < 12; i++) begin
      send_beat(mprm_pkg::FUNC_SAMPLE, 4'($urandom), rand_sample());
      send_beat(mprm_pkg::FUNC_TICK, 4'd0, 24'h0);
    end
  endtask

  // Receiver: stall on a changing pattern, or hold off when asked.
  initial begin
    int cyc;
    int hold_cnt;
    cyc = 0;
    hold_cnt = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_off_req > 0) begin
        hold_cnt = hold_off_req;
        hold_off_req = 0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else begin
        case ((cyc / 97) % 3)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 1) == 1);
          default: m_axis_tready <= (cyc % 4 != 0);
        endcase
      end
    end
  end

  // Check each report beat against the oldest prediction.
  always @(posedge clk) begin
    report_t exp_r, got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[3:0], m_axis_tdata[13:4], m_axis_tdata[23:14],
             m_axis_tdata[24], m_axis_tlast};
      n_reports++;
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report beat %h", $time, got);
        errors++;
      end else begin
        exp_r = pending_reports.pop_front();
        if (got !== exp_r) begin
          $display("%0t: report mismatch expected ch=%0d rms=%0d peak=%0d ovl=%0b last=%0b",
                   $time, exp_r.chan, $signed(exp_r.rms), $signed(exp_r.peak),
                   exp_r.ovl, exp_r.last);
          $display("%0t:                  actual ch=%0d rms=%0d peak=%0d ovl=%0b last=%0b",
                   $time, got.chan, $signed(got.rms), $signed(got.peak), got.ovl, got.last);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress, %0d reports outstanding", $time, pending_reports.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    errors = 0;
    n_samples = 0;
    n_ticks = 0;
    n_reports = 0;
    burst_left = 0;
    bursty = 1'b1;
    hold_off_req = 0;
    quiet_cycles = 0;
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    reset_model();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    test_random();
    test_backpressure();
    drain();
    $display("Covered %0d sample beats and %0d ticks, %0d report beats checked.",
             n_samples, n_ticks, n_reports);
    $display("Settings swept channel count 0..63 and hold 0..63, with long receiver hold-off.");
    if (errors == 0 && pending_reports.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire

### files.f
hdl/mprm_pkg.sv
hdl/mprm_log2.sv
hdl/mprm_level.sv
hdl/mprm_store.sv
hdl/multichannel_peak_rms_meter_unit.sv
tb/multichannel_peak_rms_meter_unit_test.sv
